@@ sv/xbrs_pkg.sv @@
package xbrs_pkg;

    localparam int unsigned DATA_W    = 64;
    localparam int unsigned HALF_W    = DATA_W / 2;
    localparam int unsigned MAX_COUNT = 64;
    localparam int unsigned CNT_W     = 7;
    localparam int unsigned KIND_W    = 3;
    localparam int unsigned WORDS     = 4;
    localparam int unsigned WIDX_W    = 2;

    localparam logic [DATA_W-1:0] SM_GAMMA = 64'h9e37_79b9_7f4a_7c15;
    localparam logic [DATA_W-1:0] SM_MUL1  = 64'hbf58_476d_1ce4_e5b9;
    localparam logic [DATA_W-1:0] SM_MUL2  = 64'h94d0_49bb_1331_11eb;

    localparam logic [DATA_W-1:0] MASK_LONG  = 64'hFFFF_FFFF_FFFF_FFFF;
    localparam logic [DATA_W-1:0] MASK_INT   = 64'h0000_0000_FFFF_FFFF;
    localparam logic [DATA_W-1:0] MASK_SHORT = 64'h0000_0000_0000_FFFF;
    localparam logic [DATA_W-1:0] MASK_BYTE  = 64'h0000_0000_0000_00FF;
    localparam logic [DATA_W-1:0] MASK_BOOL  = 64'h0000_0000_0000_0001;

    typedef enum logic [KIND_W-1:0] {
        KIND_LONG  = 3'd0,
        KIND_INT   = 3'd1,
        KIND_SHORT = 3'd2,
        KIND_BYTE  = 3'd3,
        KIND_BOOL  = 3'd4
    } kind_t;

    typedef enum logic [3:0] {
        ST_SEED_INIT,
        ST_MIX_ADD,
        ST_MUL1_GO,
        ST_MUL1_WAIT,
        ST_MUL2_GO,
        ST_MUL2_WAIT,
        ST_MIX_STORE,
        ST_IDLE,
        ST_PREP,
        ST_GEN,
        ST_DIV_WAIT,
        ST_OUT
    } state_t;

endpackage

@@ sv/xoshiro_bounded_random_source.sv @@
// path: after the input transfer a request passes PREP and GEN (count > 0); with a positive bound it then
//   waits on the serial remainder in DIV_WAIT before OUT, with a zero or non-positive bound it
//   goes straight from GEN to OUT; each later value starts again from GEN after the output transfer
// requests: one at a time; s_tready high only in idle
// reseed: four splitmix rounds, two 3-pass multiplies each, run first on a change
// reset: rst_n asynchronous active low; seed clears to zero, s_tready rises once the reseed from it is done
module xoshiro_bounded_random_source
(
    input  logic                        clk,
    input  logic                        rst_n,
    // stream in
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [71:0]                 s_tdata,  // bound[63:0], count[70:64], zero pad
    input  logic [xbrs_pkg::KIND_W-1:0] s_tuser,  // kind[2:0]
    // stream out
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [xbrs_pkg::DATA_W-1:0] m_tdata,  // value[63:0]
    output logic                        m_tlast,
    // register port
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [3:0]                  paddr,
    input  logic [xbrs_pkg::DATA_W-1:0] pwdata,
    output logic [xbrs_pkg::DATA_W-1:0] prdata,
    output logic                        pready
);
    import xbrs_pkg::*;

    state_t            state_reg;
    state_t            state_next;

    // configuration
    logic [DATA_W-1:0] seed_reg;
    logic              cfg_wr;

    // generator state and splitmix working registers
    logic [DATA_W-1:0] words_reg [WORDS];
    logic [DATA_W-1:0] words_next [WORDS];
    logic [DATA_W-1:0] applied_reg;
    logic [DATA_W-1:0] applied_next;
    logic [DATA_W-1:0] acc_reg;
    logic [DATA_W-1:0] acc_next;
    logic [DATA_W-1:0] z_reg;
    logic [DATA_W-1:0] z_next;
    logic [WIDX_W-1:0] widx_reg;
    logic [WIDX_W-1:0] widx_next;

    // request registers
    logic [CNT_W-1:0]  cnt_reg;
    logic [CNT_W-1:0]  cnt_next;
    logic [DATA_W-1:0] mask_reg;
    logic [DATA_W-1:0] mask_next;
    logic [DATA_W-1:0] bnd_reg;
    logic [DATA_W-1:0] bnd_next;
    logic              full_reg;
    logic              full_next;
    logic              pos_reg;
    logic              pos_next;
    logic              bool_reg;
    logic              bool_next;

    // result register
    logic [DATA_W-1:0] value_reg;
    logic [DATA_W-1:0] value_next;
    logic              last_reg;
    logic              last_next;

    // request decode
    logic [DATA_W-1:0] in_bound;
    logic [CNT_W-1:0]  in_count;
    logic [CNT_W-1:0]  in_cnt_sat;
    logic [DATA_W-1:0] dec_mask;
    logic [DATA_W-1:0] dec_bnd;
    logic              dec_pos;
    logic              dec_bool;

    // xoshiro256** output and next state
    logic [DATA_W-1:0] x5;
    logic [DATA_W-1:0] xrot;
    logic [DATA_W-1:0] adv_res;
    logic [DATA_W-1:0] t2;
    logic [DATA_W-1:0] t3;
    logic [DATA_W-1:0] t1;
    logic [DATA_W-1:0] t0;
    logic [DATA_W-1:0] splitmix_out;

    // multiplier and remainder units
    logic              mul_start;
    logic [DATA_W-1:0] mul_a;
    logic [DATA_W-1:0] mul_b;
    logic              mul_done;
    logic [DATA_W-1:0] mul_prod;
    logic              div_start;
    logic              div_done;
    logic [DATA_W-1:0] div_rem;

    logic              s_xfer;
    logic              m_xfer;

    xbrs_mul64 u_mul
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_start),
        .a     (mul_a),
        .b     (mul_b),
        .done  (mul_done),
        .prod  (mul_prod)
    );

    xbrs_rem64 u_rem
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (adv_res),
        .divisor  (bnd_reg),
        .done     (div_done),
        .rem      (div_rem)
    );

    // register port: one 64-bit register at byte address 0
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[3] == 1'b0);
    assign prdata = (paddr[3] == 1'b0) ? seed_reg : '0;

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = (state_reg == ST_OUT);
    assign m_tdata  = value_reg;
    assign m_tlast  = last_reg;
    assign s_xfer   = s_tvalid && s_tready;
    assign m_xfer   = m_tvalid && m_tready;

    assign in_bound   = s_tdata[DATA_W-1:0];
    assign in_count   = s_tdata[DATA_W+CNT_W-1:DATA_W];
    assign in_cnt_sat = (in_count > CNT_W'(MAX_COUNT)) ? CNT_W'(MAX_COUNT) : in_count;

    // bound truncation per kind; codes above bool fall back to long
    always_comb
    begin
        dec_bool = 1'b0;
        case (kind_t'(s_tuser))
            KIND_INT:
            begin
                dec_mask = MASK_INT;
                dec_bnd  = in_bound & MASK_INT;
                dec_pos  = (dec_bnd != '0) && !in_bound[31];
            end
            KIND_SHORT:
            begin
                dec_mask = MASK_SHORT;
                dec_bnd  = in_bound & MASK_SHORT;
                dec_pos  = (dec_bnd != '0) && !in_bound[15];
            end
            KIND_BYTE:
            begin
                dec_mask = MASK_BYTE;
                dec_bnd  = in_bound & MASK_BYTE;
                dec_pos  = (dec_bnd != '0);
            end
            KIND_BOOL:
            begin
                dec_mask = MASK_BOOL;
                dec_bnd  = in_bound;
                dec_pos  = (in_bound != '0) && !in_bound[DATA_W-1];
                dec_bool = 1'b1;
            end
            default:
            begin
                dec_mask = MASK_LONG;
                dec_bnd  = in_bound;
                dec_pos  = (in_bound != '0) && !in_bound[DATA_W-1];
            end
        endcase
    end

    // xoshiro256** scrambler: rotl(w1 * 5, 7) * 9, both constants by shift and add
    always_comb
    begin
        x5      = (words_reg[1] << 2) + words_reg[1];
        xrot    = {x5[DATA_W-8:0], x5[DATA_W-1:DATA_W-7]};
        adv_res = (xrot << 3) + xrot;
        t2      = words_reg[2] ^ words_reg[0];
        t3      = words_reg[3] ^ words_reg[1];
        t1      = words_reg[1] ^ t2;
        t0      = words_reg[0] ^ t3;
    end

    assign splitmix_out = z_reg ^ (z_reg >> 30'd31);

    // both multiplies of a splitmix round go through the shared multiplier
    assign mul_a = (state_reg == ST_MUL1_GO) ? (z_reg ^ (z_reg >> 30)) : (z_reg ^ (z_reg >> 27));
    assign mul_b = (state_reg == ST_MUL1_GO) ? SM_MUL1 : SM_MUL2;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_SEED_INIT;
        else
            state_reg <= state_next;
    end

    // sequencer
    always_comb
    begin
        state_next   = state_reg;
        words_next   = words_reg;
        applied_next = applied_reg;
        acc_next     = acc_reg;
        z_next       = z_reg;
        widx_next    = widx_reg;
        cnt_next     = cnt_reg;
        mask_next    = mask_reg;
        bnd_next     = bnd_reg;
        full_next    = full_reg;
        pos_next     = pos_reg;
        bool_next    = bool_reg;
        value_next   = value_reg;
        last_next    = last_reg;
        mul_start    = 1'b0;
        div_start    = 1'b0;

        unique case (state_reg)
            // reseed: four splitmix64 rounds fill the generator words
            ST_SEED_INIT:
            begin
                acc_next     = seed_reg;
                applied_next = seed_reg;
                widx_next    = '0;
                state_next   = ST_MIX_ADD;
            end
            ST_MIX_ADD:
            begin
                acc_next   = acc_reg + SM_GAMMA;
                z_next     = acc_reg + SM_GAMMA;
                state_next = ST_MUL1_GO;
            end
            ST_MUL1_GO:
            begin
                mul_start  = 1'b1;
                state_next = ST_MUL1_WAIT;
            end
            ST_MUL1_WAIT:
            begin
                if (mul_done)
                begin
                    z_next     = mul_prod;
                    state_next = ST_MUL2_GO;
                end
            end
            ST_MUL2_GO:
            begin
                mul_start  = 1'b1;
                state_next = ST_MUL2_WAIT;
            end
            ST_MUL2_WAIT:
            begin
                if (mul_done)
                begin
                    z_next     = mul_prod;
                    state_next = ST_MIX_STORE;
                end
            end
            ST_MIX_STORE:
            begin
                words_next[widx_reg] = splitmix_out;
                widx_next            = widx_reg + WIDX_W'(1);
                if (widx_reg == WIDX_W'(WORDS - 1))
                    state_next = ST_PREP;
                else
                    state_next = ST_MIX_ADD;
            end
            ST_IDLE:
            begin
                if (s_xfer)
                begin
                    cnt_next   = in_cnt_sat;
                    mask_next  = dec_mask;
                    bnd_next   = dec_bnd;
                    full_next  = (in_bound == '0);
                    pos_next   = dec_pos;
                    bool_next  = dec_bool;
                    state_next = ST_PREP;
                end
            end
            // a changed seed is applied before the request, even for count zero
            ST_PREP:
            begin
                if (seed_reg != applied_reg)
                    state_next = ST_SEED_INIT;
                else if (cnt_reg == '0)
                    state_next = ST_IDLE;
                else
                    state_next = ST_GEN;
            end
            ST_GEN:
            begin
                last_next = (cnt_reg == CNT_W'(1));
                if (full_reg || pos_reg)
                begin
                    words_next[0] = t0;
                    words_next[1] = t1;
                    words_next[2] = t2 ^ (words_reg[1] << 17);
                    words_next[3] = {t3[DATA_W-46:0], t3[DATA_W-1:DATA_W-45]};
                end
                if (full_reg)
                begin
                    value_next = adv_res & mask_reg;
                    state_next = ST_OUT;
                end
                else if (pos_reg)
                begin
                    // remainder unit latches adv_res before the words move on
                    div_start  = 1'b1;
                    state_next = ST_DIV_WAIT;
                end
                else
                begin
                    value_next = '0;
                    state_next = ST_OUT;
                end
            end
            ST_DIV_WAIT:
            begin
                if (div_done)
                begin
                    if (bool_reg)
                        value_next = {{(DATA_W-1){1'b0}}, (div_rem != '0)};
                    else
                        value_next = div_rem & mask_reg;
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (m_xfer)
                begin
                    cnt_next = cnt_reg - CNT_W'(1);
                    if (last_reg)
                        state_next = ST_IDLE;
                    else
                        state_next = ST_GEN;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_reg <= '0;
            cnt_reg  <= '0;
            widx_reg <= '0;
        end
        else
        begin
            if (cfg_wr)
                seed_reg <= pwdata;
            cnt_reg  <= cnt_next;
            widx_reg <= widx_next;
        end
    end

    // payload, loaded by the sequencer before first use
    always_ff @(posedge clk)
    begin
        words_reg   <= words_next;
        applied_reg <= applied_next;
        acc_reg     <= acc_next;
        z_reg       <= z_next;
        mask_reg    <= mask_next;
        bnd_reg     <= bnd_next;
        full_reg    <= full_next;
        pos_reg     <= pos_next;
        bool_reg    <= bool_next;
        value_reg   <= value_next;
        last_reg    <= last_next;
    end

`ifndef SYNTHESIS
    a_no_accept_while_out: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !s_tready)
        else $error("input accepted while a result is pending");

    a_div_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == ST_DIV_WAIT))
        else $error("remainder finished outside its wait state");

    a_out_has_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_OUT) |-> (cnt_reg != '0) && (last_reg == (cnt_reg == CNT_W'(1))))
        else $error("result count out of step with last flag");

    a_last_goes_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (m_xfer && m_tlast) |=> (state_reg == ST_IDLE))
        else $error("request did not end on last transfer");
`endif

endmodule

@@ sv/xbrs_mul64.sv @@
module xbrs_mul64
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [xbrs_pkg::DATA_W-1:0] a,
    input  logic [xbrs_pkg::DATA_W-1:0] b,
    output logic                      done,
    output logic [xbrs_pkg::DATA_W-1:0] prod
);
    import xbrs_pkg::*;

    logic [DATA_W-1:0] a_reg;
    logic [DATA_W-1:0] b_reg;
    logic [DATA_W-1:0] acc_reg;
    logic [DATA_W-1:0] acc_next;
    logic [1:0]        phase_reg;
    logic              busy_reg;
    logic              done_reg;
    logic [HALF_W-1:0] op_a;
    logic [HALF_W-1:0] op_b;
    logic [DATA_W-1:0] part;

    // one 32x32 multiplier, low 64 bits of the 128-bit product in three passes
    always_comb
    begin
        op_a = a_reg[HALF_W-1:0];
        op_b = b_reg[HALF_W-1:0];
        case (phase_reg)
            2'd1:    op_a = a_reg[DATA_W-1:HALF_W];
            2'd2:    op_b = b_reg[DATA_W-1:HALF_W];
            default: op_a = a_reg[HALF_W-1:0];
        endcase
        part = DATA_W'(op_a) * DATA_W'(op_b);
        if (phase_reg == 2'd0)
            acc_next = part;
        else
            acc_next = acc_reg + {part[HALF_W-1:0], {HALF_W{1'b0}}};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            phase_reg <= 2'd0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg  <= 1'b1;
                phase_reg <= 2'd0;
            end
            else if (busy_reg)
            begin
                phase_reg <= phase_reg + 2'd1;
                if (phase_reg == 2'd2)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            a_reg <= a;
            b_reg <= b;
        end
        if (busy_reg)
            acc_reg <= acc_next;
    end

    assign done = done_reg;
    assign prod = acc_reg;

`ifndef SYNTHESIS
    a_mul_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> !busy_reg)
        else $error("multiplier started while busy");
`endif

endmodule

@@ sv/xbrs_rem64.sv @@
module xbrs_rem64
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [xbrs_pkg::DATA_W-1:0] dividend,
    input  logic [xbrs_pkg::DATA_W-1:0] divisor,
    output logic                        done,
    output logic [xbrs_pkg::DATA_W-1:0] rem
);
    import xbrs_pkg::*;

    logic [DATA_W-1:0] q_reg;
    logic [DATA_W-1:0] r_reg;
    logic [DATA_W-1:0] d_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic              busy_reg;
    logic              done_reg;
    logic [DATA_W-1:0] r_shift;
    logic [DATA_W-1:0] r_next;

    // restoring remainder, one dividend bit per cycle; divisor stays below 2^63
    always_comb
    begin
        r_shift = {r_reg[DATA_W-2:0], q_reg[DATA_W-1]};
        if (r_shift >= d_reg)
            r_next = r_shift - d_reg;
        else
            r_next = r_shift;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(DATA_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            q_reg <= dividend;
            d_reg <= divisor;
            r_reg <= '0;
        end
        else if (busy_reg)
        begin
            q_reg <= {q_reg[DATA_W-2:0], 1'b0};
            r_reg <= r_next;
        end
    end

    assign done = done_reg;
    assign rem  = r_reg;

`ifndef SYNTHESIS
    a_rem_below_divisor: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> (r_reg < d_reg))
        else $error("remainder not below divisor");
`endif

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 1ps

module tb;
    import xbrs_pkg::*;

    localparam int CLK_HALF      = 4;
    localparam int RESET_CYCLES  = 8;
    // a zero-count request may leave a reseed running after the last value
    localparam int SETTLE_CYCLES = 150;
    localparam int TAIL_CYCLES   = 200;
    localparam int IDLE_LIMIT    = 4000;
    localparam int MAX_REPORTS   = 10;
    localparam int RAND_PHASES   = 6;
    localparam int PHASE_ITEMS   = 21;
    localparam int DIRECTED_N    = 27;

    localparam int unsigned REG_SEED  = 0;
    localparam logic [3:0]  ADDR_SEED = 4'(REG_SEED * 8);

    // kind codes past bool, served as long
    localparam logic [KIND_W-1:0] KIND_SPARE5 = 3'd5;
    localparam logic [KIND_W-1:0] KIND_SPARE7 = 3'd7;

    typedef struct packed {
        logic              set_seed;     // write the seed register before this request
        logic [63:0]       seed;
        logic [KIND_W-1:0] kind;
        logic [63:0]       bound;
        logic [CNT_W-1:0]  count;
        logic              typed;        // expected value given in the row
        logic [63:0]       typed_value;
    } request_t;

    typedef struct packed {
        logic [DATA_W-1:0] value;
        logic              last;
    } value_item_t;

    logic              clk;
    logic              rst_n;
    logic              s_tvalid;
    logic              s_tready;
    logic [71:0]       s_tdata;   // bound[63:0], count[70:64], zero pad
    logic [KIND_W-1:0] s_tuser;   // kind[2:0]
    logic              m_tvalid;
    logic              m_tready;
    logic [DATA_W-1:0] m_tdata;   // value[63:0]
    logic              m_tlast;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [3:0]        paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    xoshiro_bounded_random_source u_top (.*);

    // shadow of the generator and of the seed register
    logic [DATA_W-1:0] gen_words_model [WORDS];
    logic [DATA_W-1:0] seed_shadow;
    logic [DATA_W-1:0] seed_in_use;

    value_item_t expected_values [$];
    request_t    directed_rows [DIRECTED_N];
    int          mismatch_count;
    int          burst_left;
    int          quiet_cycles;
    int unsigned cycle_count;
    int          stall_mode;

    always #(CLK_HALF) clk = ~clk;

    function automatic logic [63:0] rotl64(input logic [63:0] v, input int unsigned amt);
        return (v << amt) | (v >> (64 - amt));
    endfunction

    function automatic logic [63:0] splitmix_scramble(input logic [63:0] acc);
        logic [63:0] z;
        z = acc;
        z = (z ^ (z >> 30)) * SM_MUL1;
        z = (z ^ (z >> 27)) * SM_MUL2;
        return z ^ (z >> 31);
    endfunction

    // four splitmix rounds fill the generator words
    function automatic void load_generator(input logic [63:0] s);
        logic [63:0] acc;
        acc = s;
        for (int i = 0; i < WORDS; i++)
        begin
            acc = acc + SM_GAMMA;
            gen_words_model[i] = splitmix_scramble(acc);
        end
        seed_in_use = s;
    endfunction

    function automatic logic [63:0] xoshiro_step();
        logic [63:0] res;
        logic [63:0] sh;
        res = rotl64(gen_words_model[1] * 64'd5, 7) * 64'd9;
        sh  = gen_words_model[1] << 17;
        gen_words_model[2] = gen_words_model[2] ^ gen_words_model[0];
        gen_words_model[3] = gen_words_model[3] ^ gen_words_model[1];
        gen_words_model[1] = gen_words_model[1] ^ gen_words_model[2];
        gen_words_model[0] = gen_words_model[0] ^ gen_words_model[3];
        gen_words_model[2] = gen_words_model[2] ^ sh;
        gen_words_model[3] = rotl64(gen_words_model[3], 45);
        return res;
    endfunction

    // values that one accepted request should produce
    function automatic void predict_request(input request_t r);
        logic [63:0] mask;
        logic [63:0] modulus;
        logic [63:0] v;
        logic        no_bound;
        logic        positive;
        logic        as_bool;
        int          n;
        value_item_t item;
        // a changed seed is applied even when no value follows
        if (seed_shadow != seed_in_use)
            load_generator(seed_shadow);
        n = (r.count > MAX_COUNT) ? MAX_COUNT : int'(r.count);
        no_bound = (r.bound == '0);
        as_bool = 1'b0;
        case (r.kind)
            KIND_INT:
            begin
                mask     = MASK_INT;
                modulus  = r.bound & MASK_INT;
                positive = (modulus != '0) && !modulus[31];
            end
            KIND_SHORT:
            begin
                mask     = MASK_SHORT;
                modulus  = r.bound & MASK_SHORT;
                positive = (modulus != '0) && !modulus[15];
            end
            KIND_BYTE:
            begin
                // byte bound is taken unsigned
                mask     = MASK_BYTE;
                modulus  = r.bound & MASK_BYTE;
                positive = (modulus != '0);
            end
            KIND_BOOL:
            begin
                mask     = MASK_BOOL;
                modulus  = r.bound;
                positive = (modulus != '0) && !modulus[63];
                as_bool  = 1'b1;
            end
            default:
            begin
                mask     = MASK_LONG;
                modulus  = r.bound;
                positive = (modulus != '0) && !modulus[63];
            end
        endcase
        for (int k = 0; k < n; k++)
        begin
            if (no_bound)
                v = xoshiro_step() & mask;
            else if (positive)
            begin
                v = xoshiro_step() % modulus;
                if (as_bool)
                    v = (v != '0) ? 64'd1 : 64'd0;
            end
            else
                v = '0;   // bound not positive: generator holds
            item.value = r.typed ? r.typed_value : (v & mask);
            item.last  = (k == n - 1);
            expected_values.push_back(item);
        end
    endfunction

    function automatic void note_mismatch(input string what, input logic [63:0] want,
                                          input logic [63:0] got);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
            $display("%0t mismatch on %s: expected %h, got %h", $time, what, want, got);
    endfunction

    // seed is written only with the block idle: drained and past any reseed
    task automatic write_seed(input logic [63:0] value);
        s_tvalid <= 1'b0;
        while (expected_values.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_SEED;
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        // register takes the value at this edge
        seed_shadow = value;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        burst_left = $urandom_range(1, 8);
    endtask

    // present one request and hold it until the transfer
    task automatic send_request(input request_t r);
        s_tvalid <= 1'b1;
        s_tdata  <= {1'b0, r.count, r.bound};
        s_tuser  <= r.kind;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        predict_request(r);
    endtask

    // sender runs in bursts with random gaps between them
    task automatic issue(input request_t r);
        int gap;
        if (r.set_seed)
            write_seed(r.seed);
        else if (burst_left <= 0)
        begin
            burst_left = $urandom_range(1, 8);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap != 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        send_request(r);
    endtask

    function automatic request_t random_request();
        request_t r;
        int       pick;
        r = '0;
        pick = $urandom_range(0, 99);
        r.kind = (pick < 88) ? 3'($urandom_range(0, 4)) : 3'($urandom_range(5, 7));
        pick = $urandom_range(0, 99);
        if (pick < 20)
            r.bound = '0;
        else if (pick < 30)
            r.bound = 64'($urandom_range(1, 3));
        else
        begin
            r.bound = {$urandom(), $urandom()} >> $urandom_range(0, 63);
            if ($urandom_range(0, 4) == 0)
                r.bound[63] = 1'b1;
        end
        pick = $urandom_range(0, 99);
        if (pick < 15)
            r.count = '0;
        else if (pick < 85)
            r.count = 7'($urandom_range(1, 6));
        else if (pick < 95)
            r.count = 7'($urandom_range(7, 20));
        else
            r.count = 7'($urandom_range(60, 127));
        return r;
    endfunction

    // output side: check each transfer, then pick the next ready
    always @(posedge clk)
    begin
        value_item_t head;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_values.size() == 0)
                note_mismatch("value with nothing expected", '0, m_tdata);
            else
            begin
                head = expected_values.pop_front();
                if (m_tdata !== head.value)
                    note_mismatch("value", head.value, m_tdata);
                if (m_tlast !== head.last)
                    note_mismatch("last", 64'(head.last), 64'(m_tlast));
            end
        end
        cycle_count++;
        if (cycle_count % 64 == 0)
            stall_mode = $urandom_range(0, 3);
        if (!rst_n)
            m_tready <= 1'b0;
        else
            case (stall_mode)
                0:       m_tready <= 1'b1;
                1:       m_tready <= ($urandom_range(0, 3) != 0);
                2:       m_tready <= ($urandom_range(0, 3) == 0);
                default: m_tready <= cycle_count[4];   // ready follows bit 4 of the cycle counter
            endcase
    end

    // watchdog on cycles without any transfer
    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)
            || (psel && penable && pwrite && pready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= IDLE_LIMIT)
        begin
            $display("tb: done, errors");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        logic [63:0] prior;
        clk      = 1'b0;
        rst_n    = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = '0;
        m_tready = 1'b0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        mismatch_count = 0;
        burst_left     = 0;
        quiet_cycles   = 0;
        cycle_count    = 0;
        stall_mode     = 0;
        seed_shadow    = '0;
        load_generator('0);

        // set_seed, seed, kind, bound, count, typed, typed value
        directed_rows = '{
            '{1'b0, 64'd0, KIND_LONG,  64'd0, 7'd1, 1'b0, 64'd0},   // first value from reset
            '{1'b0, 64'd0, KIND_LONG,  64'd0, 7'd3, 1'b0, 64'd0},
            '{1'b0, 64'd0, KIND_INT,   64'd0, 7'd2, 1'b0, 64'd0},   // full range, masked
            '{1'b0, 64'd0, KIND_SHORT, 64'd0, 7'd2, 1'b0, 64'd0},
            '{1'b0, 64'd0, KIND_BYTE,  64'd0, 7'd2, 1'b0, 64'd0},
            '{1'b0, 64'd0, KIND_BOOL,  64'd0, 7'd4, 1'b0, 64'd0},   // low bit only
            '{1'b0, 64'd0, KIND_LONG,  64'd1, 7'd2, 1'b1, 64'd0},   // mod one
            '{1'b0, 64'd0, KIND_LONG,  64'h7FFF_FFFF_FFFF_FFFF, 7'd2, 1'b0, 64'd0},
            '{1'b0, 64'd0, KIND_LONG,  64'h8000_0000_0000_0000, 7'd2, 1'b1, 64'd0},
            '{1'b0, 64'd0, KIND_LONG,  64'hFFFF_FFFF_FFFF_FFFF, 7'd1, 1'b1, 64'd0},
            '{1'b0, 64'd0, KIND_INT,   64'h0000_0000_7FFF_FFFF, 7'd2, 1'b0, 64'd0},
            '{1'b0, 64'd0, KIND_INT,   64'hFFFF_FFFF_8000_0000, 7'd1, 1'b1, 64'd0},
            '{1'b0, 64'd0, KIND_INT,   64'h0000_0001_0000_0000, 7'd1, 1'b1, 64'd0},
            '{1'b0, 64'd0, KIND_SHORT, 64'h1234_0000_0000_7FFF, 7'd2, 1'b0, 64'd0},
            '{1'b0, 64'd0, KIND_SHORT, 64'h0000_0000_0000_8000, 7'd1, 1'b1, 64'd0},
            '{1'b0, 64'd0, KIND_BYTE,  64'hFFFF_FFFF_FFFF_FF80, 7'd2, 1'b0, 64'd0},
            '{1'b0, 64'd0, KIND_BYTE,  64'h0000_0000_0000_0100, 7'd1, 1'b1, 64'd0},
            '{1'b0, 64'd0, KIND_BYTE,  64'h0000_0000_0000_00FF, 7'd2, 1'b0, 64'd0},
            '{1'b0, 64'd0, KIND_BOOL,  64'd3, 7'd4, 1'b0, 64'd0},   // nonzero remainder folds to one
            '{1'b0, 64'd0, KIND_BOOL,  64'd1, 7'd1, 1'b1, 64'd0},
            '{1'b0, 64'd0, KIND_BOOL,  64'hFFFF_FFFF_FFFF_FFFB, 7'd1, 1'b1, 64'd0},
            '{1'b0, 64'd0, KIND_SPARE5, 64'd0, 7'd1, 1'b0, 64'd0},  // unknown kind as long
            '{1'b0, 64'd0, KIND_SPARE7, 64'd10, 7'd2, 1'b0, 64'd0},
            '{1'b0, 64'd0, KIND_LONG,  64'd100, 7'd127, 1'b0, 64'd0},  // count saturates
            // zero count still reseeds; going back to the old seed then reseeds again
            '{1'b1, 64'hDEAD_BEEF_0BAD_F00D, KIND_LONG, 64'd1000, 7'd0, 1'b0, 64'd0},
            '{1'b1, 64'd0, KIND_LONG, 64'd0, 7'd4, 1'b0, 64'd0},
            '{1'b1, 64'h0123_4567_89AB_CDEF, KIND_BYTE, 64'd200, 7'd65, 1'b0, 64'd0}
        };

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        foreach (directed_rows[i])
            issue(directed_rows[i]);

        // random phases, each opened by seed writes, extremes among them
        for (int p = 0; p < RAND_PHASES; p++)
        begin
            case (p)
                0: write_seed(64'hFFFF_FFFF_FFFF_FFFF);
                2: write_seed('0);
                3:
                begin
                    // new seed and straight back: nothing to apply
                    prior = seed_shadow;
                    write_seed({$urandom(), $urandom()});
                    write_seed(prior);
                end
                4: write_seed(64'h8000_0000_0000_0000);
                default: write_seed({$urandom(), $urandom()});
            endcase
            for (int j = 0; j < PHASE_ITEMS; j++)
                issue(random_request());
        end

        s_tvalid <= 1'b0;
        while (expected_values.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (mismatch_count == 0 && expected_values.size() == 0)
            $display("tb: done, clean");
        else
            $display("tb: done, errors");
        $finish;
    end

endmodule

@@ files.f @@
sv/xbrs_pkg.sv
sv/xbrs_mul64.sv
sv/xbrs_rem64.sv
sv/xoshiro_bounded_random_source.sv
tb/tb.sv
